// ----- hw/rtl/gmg_pkg.sv -----
// Shared constants, types and the exponent table of the Gaussian membership grade block.
package gmg_pkg;

    // Result width and exponent table size
    localparam int GRADE_BITS      = 16;
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int IDX_BITS        = $clog2(EXP_TABLE_DEPTH);
    localparam int SERIES_TERMS    = 16;

    // Stream payload widths, padded to whole bytes
    localparam int X_BITS          = 16;
    localparam int GRADE_DATA_BITS = ((GRADE_BITS + 7) / 8) * 8;

    // Datapath widths
    localparam int D_BITS     = X_BITS + 1;    // x - m
    localparam int AD_BITS    = X_BITS;        // |x - m|
    localparam int S_BITS     = 2 * AD_BITS;   // square, Q16.16
    localparam int Y_BITS     = S_BITS + 16;   // k * square, Q24.24
    localparam int HALF_BITS  = Y_BITS / 2;    // split point of y for the log2(e) product
    localparam int PP_BITS    = HALF_BITS + 16;
    localparam int PROD_BITS  = Y_BITS + 16;
    localparam int T_BITS     = PROD_BITS - 15;
    localparam int FRAC_BITS  = 24;
    localparam int N_BITS     = T_BITS - FRAC_BITS;
    localparam int SHIFT_BITS = 6;             // shift counts of 64 and up give zero
    localparam int ENTRY_BITS = 33;            // Q0.32 plus the entry for 1.0
    localparam int IPROD_BITS = FRAC_BITS + IDX_BITS + 1;

    // Fixed-point constants
    localparam logic [15:0] LOG2E_Q15 = 16'd47274;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [ENTRY_BITS-1:0] GRADE_MAX =
        ENTRY_BITS'((64'd1 << GRADE_BITS) - 64'd1);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH_K     = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_M    = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_LIMIT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_LIMIT = 8'd3;

    // Configuration reset values
    localparam logic        [15:0] RST_WIDTH_K     = 16'd256;
    localparam logic signed [15:0] RST_CENTER_M    = 16'sd0;
    localparam logic signed [15:0] RST_LOWER_LIMIT = 16'sh8000;
    localparam logic signed [15:0] RST_UPPER_LIMIT = 16'sh7FFF;

    typedef struct packed {
        logic        [15:0] width_k;
        logic signed [15:0] center_m;
        logic signed [15:0] lower_limit;
        logic signed [15:0] upper_limit;
    } t_cfg;

    typedef logic [EXP_TABLE_DEPTH-1:0][ENTRY_BITS-1:0] t_exp_table;

    // Entry i holds 2^(-i/depth) in Q0.32 from a series of exp(-a) truncated after the a^16 term
    function automatic t_exp_table build_exp_table();
        t_exp_table  tbl;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            a    = (64'(LN2_Q32) * 64'(i)) / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 32;
            sum  = 64'd1 << 32;
            for (int k = 1; k <= SERIES_TERMS; k++) begin
                term = ((term * a) >> 32) / 64'(k);
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            tbl[i] = sum[ENTRY_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam t_exp_table EXP_TABLE = build_exp_table();

endpackage

// ----- hw/rtl/gmg_cfg.sv -----
// Configuration register file of the Gaussian membership grade block.
module gmg_cfg
    import gmg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    // Take a write in every cycle
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_k     <= RST_WIDTH_K;
            r_cfg.center_m    <= RST_CENTER_M;
            r_cfg.lower_limit <= RST_LOWER_LIMIT;
            r_cfg.upper_limit <= RST_UPPER_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH_K:     r_cfg.width_k     <= i_cfg_data;
                CFG_CENTER_M:    r_cfg.center_m    <= i_cfg_data;
                CFG_LOWER_LIMIT: r_cfg.lower_limit <= i_cfg_data;
                CFG_UPPER_LIMIT: r_cfg.upper_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/gaussian_membership_grade.sv -----
// Gaussian membership grade exp(-k*(x-m)^2): seven-stage pipeline, one item per cycle
// while the output takes results; every stage holds under output backpressure and
// empty stages fill up, so input ready falls only when all seven stages are full
// and the output is not ready.
// Reset (synchronous, active low) empties the pipeline and sets the registers to
// k = 1.0, m = 0, limits to the full input range.
module gaussian_membership_grade
    import gmg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    // Input items
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [X_BITS-1:0]          s_axis_tdata,   // [15:0] crisp_value
    // Result items
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [GRADE_DATA_BITS-1:0] m_axis_tdata,   // [GRADE_BITS-1:0] grade
    output logic                       m_axis_tuser    // [0] outside_limits
);

    localparam int NSTAGES = 7;

    t_cfg w_cfg;

    gmg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic [NSTAGES:1] r_vld;
    logic [NSTAGES:1] w_adv;
    logic [NSTAGES:1] r_oor;

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        w_adv[NSTAGES] = !r_vld[NSTAGES] || m_axis_tready;
        for (int i = NSTAGES - 1; i >= 1; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    assign s_axis_tready = w_adv[1];

    // Move valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int i = 2; i <= NSTAGES; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Stage 1: range check and distance to the center
    logic signed [X_BITS-1:0] w_x;
    logic signed [D_BITS-1:0] n_d;
    logic        [D_BITS-1:0] w_neg_d;
    logic        [AD_BITS-1:0] n_ad;
    logic        [AD_BITS-1:0] r_ad1;

    always_comb begin
        w_x     = s_axis_tdata;
        n_d     = D_BITS'(w_x) - D_BITS'(w_cfg.center_m);
        w_neg_d = -n_d;
        n_ad    = n_d[D_BITS-1] ? w_neg_d[AD_BITS-1:0] : n_d[AD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_ad1 <= n_ad;
        end
    end

    // Set the out-of-range flag and carry it down the pipe
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_oor[1] <= (w_x < w_cfg.lower_limit) || (w_x > w_cfg.upper_limit);
        end
        for (int i = 2; i <= NSTAGES; i++) begin
            if (w_adv[i]) begin
                r_oor[i] <= r_oor[i-1];
            end
        end
    end

    // Stage 2: square of the distance
    logic [S_BITS-1:0] r_s2;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s2 <= S_BITS'(r_ad1) * S_BITS'(r_ad1);
        end
    end

    // Stage 3: scale by the width factor
    logic [Y_BITS-1:0] r_y3;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_y3 <= Y_BITS'(w_cfg.width_k) * Y_BITS'(r_s2);
        end
    end

    // Stage 4: log2(e) partial products on both halves of y
    logic [PP_BITS-1:0] r_plo4;
    logic [PP_BITS-1:0] r_phi4;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_plo4 <= PP_BITS'(r_y3[HALF_BITS-1:0]) * PP_BITS'(LOG2E_Q15);
            r_phi4 <= PP_BITS'(r_y3[Y_BITS-1:HALF_BITS]) * PP_BITS'(LOG2E_Q15);
        end
    end

    // Stage 5: sum partial products, split t into shift and fraction
    logic [PROD_BITS-1:0]  n_prod;
    logic [T_BITS-1:0]     w_t;
    logic [N_BITS-1:0]     w_n;
    logic                  r_zero5;
    logic [SHIFT_BITS-1:0] r_shift5;
    logic [FRAC_BITS-1:0]  r_frac5;

    always_comb begin
        n_prod = {r_phi4, HALF_BITS'(0)} + PROD_BITS'(r_plo4);
        w_t    = n_prod[PROD_BITS-1:15];
        w_n    = w_t[T_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_zero5  <= |w_n[N_BITS-1:SHIFT_BITS];
            r_shift5 <= w_n[SHIFT_BITS-1:0];
            r_frac5  <= w_t[FRAC_BITS-1:0];
        end
    end

    // Stage 6: table lookup of 2^-f
    logic [IPROD_BITS-1:0] n_iprod;
    logic [IDX_BITS:0]     w_idx_full;
    logic [IDX_BITS-1:0]   n_idx;
    logic                  r_zero6;
    logic [SHIFT_BITS-1:0] r_shift6;
    logic [ENTRY_BITS-1:0] r_entry6;

    always_comb begin
        n_iprod    = IPROD_BITS'(r_frac5) * IPROD_BITS'(EXP_TABLE_DEPTH);
        w_idx_full = n_iprod[IPROD_BITS-1:FRAC_BITS];
        if (w_idx_full >= (IDX_BITS + 1)'(EXP_TABLE_DEPTH)) begin
            n_idx = IDX_BITS'(EXP_TABLE_DEPTH - 1);
        end else begin
            n_idx = w_idx_full[IDX_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_zero6  <= r_zero5;
            r_shift6 <= r_shift5;
            r_entry6 <= EXP_TABLE[n_idx];
        end
    end

    // Stage 7: shift by the integer part, saturate, zero on out of range or a shift of 64 and up
    logic [ENTRY_BITS-1:0] n_val;
    logic [GRADE_BITS-1:0] n_grade;
    logic [GRADE_BITS-1:0] r_grade7;

    always_comb begin
        n_val = (r_entry6 >> (32 - GRADE_BITS)) >> r_shift6;
        if (r_oor[6] || r_zero6) begin
            n_grade = '0;
        end else if (n_val > GRADE_MAX) begin
            n_grade = '1;
        end else begin
            n_grade = n_val[GRADE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r_grade7 <= n_grade;
        end
    end

    assign m_axis_tvalid = r_vld[NSTAGES];
    assign m_axis_tdata  = GRADE_DATA_BITS'(r_grade7);
    assign m_axis_tuser  = r_oor[NSTAGES];

endmodule
